/* design/jxesc_pkg.sv */
// Package with the mode codes, character constants and escape function of the escaper.
package jxesc_pkg;

  typedef enum logic [1:0] {
    ModeNone = 2'd0,
    ModeXml  = 2'd1,
    ModeJson = 2'd2
  } escmode_e;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned CharW  = 8;
  localparam int unsigned MaxRun = 6;
  localparam int unsigned LenW   = $clog2(MaxRun + 1);
  localparam int unsigned RemW   = $clog2(MaxRun);

  localparam logic [CharW-1:0] CharAmp   = 8'h26;
  localparam logic [CharW-1:0] CharLt    = 8'h3c;
  localparam logic [CharW-1:0] CharGt    = 8'h3e;
  localparam logic [CharW-1:0] CharQuot  = 8'h22;
  localparam logic [CharW-1:0] CharApos  = 8'h27;
  localparam logic [CharW-1:0] CharBslash = 8'h5c;
  localparam logic [CharW-1:0] CharBs    = 8'h08;
  localparam logic [CharW-1:0] CharFf    = 8'h0c;
  localparam logic [CharW-1:0] CharLf    = 8'h0a;
  localparam logic [CharW-1:0] CharCr    = 8'h0d;
  localparam logic [CharW-1:0] CharTab   = 8'h09;

  typedef struct packed {
    logic [UnitW-1:0]                  unit0;
    logic [MaxRun-2:0][CharW-1:0]      rest;
    logic [LenW-1:0]                   len;
  } run_t;

  // Builds a run from a right-justified ASCII string of the given length.
  function automatic run_t text_run(input logic [MaxRun*CharW-1:0] s,
                                    input logic [LenW-1:0] len);
    logic [MaxRun-1:0][CharW-1:0] txt;
    run_t r;
    txt = '0;
    for (int k = 0; k < MaxRun; k++) begin
      if (k < int'(len)) begin
        txt[k] = s[CharW*(int'(len) - 1 - k) +: CharW];
      end
    end
    r.unit0 = {{(UnitW-CharW){1'b0}}, txt[0]};
    r.rest  = txt[MaxRun-1:1];
    r.len   = len;
    return r;
  endfunction

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] n);
    logic [CharW-1:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'h0, n};
    end else begin
      c = 8'h57 + {4'h0, n};
    end
    return c;
  endfunction

  function automatic logic [UnitW-1:0] as_unit(input logic [CharW-1:0] c);
    return {{(UnitW-CharW){1'b0}}, c};
  endfunction

  // Computes the whole escaped run for one code unit.
  function automatic run_t escape_unit(input logic [1:0] mode,
                                       input logic [UnitW-1:0] cu);
    run_t r;
    r.unit0 = cu;
    r.rest  = '0;
    r.len   = LenW'(1);
    if (mode == ModeXml) begin
      unique case (cu)
        as_unit(CharAmp):  r = text_run(48'("&amp;"), LenW'(5));
        as_unit(CharLt):   r = text_run(48'("&lt;"), LenW'(4));
        as_unit(CharGt):   r = text_run(48'("&gt;"), LenW'(4));
        as_unit(CharQuot): r = text_run(48'("&quot;"), LenW'(6));
        as_unit(CharApos): r = text_run(48'("&apos;"), LenW'(6));
        default: ;
      endcase
    end else if (mode == ModeJson) begin
      unique case (cu)
        as_unit(CharQuot):   r = text_run(48'("\\\""), LenW'(2));
        as_unit(CharBslash): r = text_run(48'("\\\\"), LenW'(2));
        as_unit(CharBs):     r = text_run(48'("\\b"), LenW'(2));
        as_unit(CharFf):     r = text_run(48'("\\f"), LenW'(2));
        as_unit(CharLf):     r = text_run(48'("\\n"), LenW'(2));
        as_unit(CharCr):     r = text_run(48'("\\r"), LenW'(2));
        as_unit(CharTab):    r = text_run(48'("\\t"), LenW'(2));
        default: begin
          if (cu[UnitW-1:5] == '0) begin
            r = text_run({32'("\\u00"), hex_char(cu[7:4]), hex_char(cu[3:0])},
                         LenW'(6));
          end
        end
      endcase
    end
    return r;
  endfunction

endpackage

/* design/json_xml_char_escaper_unit.sv */
// Top level of the JSON and XML character escaper.
// A result strobe is registered and follows an accepted transaction in the next cycle.
// Throughput: one input per cycle for plain units; an escaped unit emits a run
// of up to six units, one per cycle from the run buffer, and busy holds off
// the next start until the last unit of the run is on the outputs.
// Reset clears the mode to none and empties the run buffer; the receiver cannot stall.
module json_xml_char_escaper_unit
  import jxesc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [15:0]      code_unit_i,
  output logic [15:0]      out_unit_o,
  output logic             last_of_run_o,
  output logic             out_strobe_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_data_i
);

  logic [1:0]                   mode_q;
  logic [UnitW-1:0]             unit_q, unit_d;
  logic                         last_q, last_d;
  logic                         strobe_q, strobe_d;
  logic [MaxRun-2:0][CharW-1:0] rest_q, rest_d;
  logic [RemW-1:0]              rem_q, rem_d;
  logic                         accept;
  run_t                         run;

  assign cfg_ready_o = 1'b1;
  assign busy        = (rem_q != '0);
  assign accept      = start && !busy;
  assign run         = escape_unit(mode_q, code_unit_i);

  always_comb begin
    unit_d   = unit_q;
    last_d   = last_q;
    strobe_d = 1'b0;
    rest_d   = rest_q;
    rem_d    = rem_q;
    if (busy) begin
      unit_d   = as_unit(rest_q[0]);
      last_d   = (rem_q == RemW'(1));
      strobe_d = 1'b1;
      rest_d   = {{CharW{1'b0}}, rest_q[MaxRun-2:1]};
      rem_d    = rem_q - RemW'(1);
    end else if (accept) begin
      unit_d   = run.unit0;
      last_d   = (run.len == LenW'(1));
      strobe_d = 1'b1;
      rest_d   = run.rest;
      rem_d    = RemW'(run.len - LenW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeNone;
      strobe_q <= 1'b0;
      rem_q    <= '0;
    end else begin
      strobe_q <= strobe_d;
      rem_q    <= rem_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
    last_q <= last_d;
    rest_q <= rest_d;
  end

  assign out_unit_o    = unit_q;
  assign last_of_run_o = last_q;
  assign out_strobe_o  = strobe_q;

`ifndef SYNTH
  a_accept_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> out_strobe_o)
    else $error("Accepted transaction produced no result strobe.");

  a_busy_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> out_strobe_o)
    else $error("Pending run unit was not emitted.");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && last_of_run_o) |-> !busy)
    else $error("Run ended while units were still pending.");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !last_of_run_o) |-> busy)
    else $error("Unfinished run left no pending units.");
`endif

endmodule
